// ===== hdl/spm_pkg.sv =====
// Shared types and constants for the script pattern hash matcher.
package spm_pkg;

   // Table size and field widths
   localparam int TABLE_ENTRIES = 64;
   localparam int CMD_W         = 2;
   localparam int ENTRY_W       = 6;
   localparam int WSEL_W        = 2;
   localparam int WORD_W        = 64;
   localparam int TAIL_W        = 32;
   localparam int BYTE_W        = 8;
   localparam int KIND_W        = 2;

   // Template geometry
   localparam int WIN_LEN    = 25;
   localparam int SH_LEN     = 23;
   localparam int FILL_W     = 5;
   localparam int HASH_BYTES = 20;
   localparam int PKH_HASH_AT = 3;
   localparam int SH_HASH_AT  = WIN_LEN - SH_LEN + 2;

   // Commands
   localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Hash word selects
   localparam logic [WSEL_W-1:0] WSEL_LOW  = 2'd0;
   localparam logic [WSEL_W-1:0] WSEL_MID  = 2'd1;
   localparam logic [WSEL_W-1:0] WSEL_TAIL = 2'd2;

   // Hit kinds
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PKH  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SH   = 2'd2;

   // Template bytes
   localparam logic [BYTE_W-1:0] OP_DUP         = 8'h76;
   localparam logic [BYTE_W-1:0] OP_HASH160     = 8'ha9;
   localparam logic [BYTE_W-1:0] OP_PUSH20      = 8'h14;
   localparam logic [BYTE_W-1:0] OP_EQUALVERIFY = 8'h88;
   localparam logic [BYTE_W-1:0] OP_CHECKSIG    = 8'hac;
   localparam logic [BYTE_W-1:0] OP_EQUAL       = 8'h87;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ENTRY_W-1:0] entry_index;
      logic [WSEL_W-1:0]  word_select;
      logic [WORD_W-1:0]  load_word;
      logic [BYTE_W-1:0]  data_byte;
      logic               last_byte;
   } spm_req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  hit_kind;
      logic [ENTRY_W-1:0] hit_entry;
      logic               file_match;
      logic               file_done;
   } spm_rsp_type;

endpackage

// ===== hdl/spm_req_if.sv =====
// Request channel: valid/ready handshake carrying one scan or table item.
interface spm_req_if;
   logic                valid;
   logic                ready;
   spm_pkg::spm_req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/spm_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one match result.
interface spm_rsp_if;
   logic                valid;
   logic                ready;
   spm_pkg::spm_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/script_pattern_hash_matcher_core.sv =====
// Top level: byte-stream script template scanner with a parallel hash table.
//
// Channels: req_chan takes one item per beat (scan a byte, write a 64-bit
// table word, or clear the table); rsp_chan returns exactly one result beat
// per request beat, in order. A beat moves when valid and ready are high.
// An accepted request passes through stage A, stage B and the output
// register to rsp_chan. Throughput: one item per cycle while rsp_chan.ready
// stays high. The rate is set by the 64-way compare of the candidate hash
// against every stored entry, which is combinational and registered,
// followed by a priority encoder into the output register.
// A table write takes effect for every item accepted after it.
// Reset (synchronous, active high) empties the pipeline, invalidates all
// table entries and starts a new file; stored hash words keep their contents.
// When the receiver stalls, results stay in the output register and the two
// pipeline stages behind it fill up; req_chan.ready drops only when all three
// stages hold items, so up to three beats are taken during a stall.
module script_pattern_hash_matcher_core (
   input  logic      clock,
   input  logic      reset,
   spm_req_if.sink   req_chan,
   spm_rsp_if.source rsp_chan
);

   localparam int NENT = spm_pkg::TABLE_ENTRIES;

   // Hash table storage (one comparator per entry)
   logic [spm_pkg::WORD_W-1:0] tbl_low_ff  [NENT];
   logic [spm_pkg::WORD_W-1:0] tbl_mid_ff  [NENT];
   logic [spm_pkg::TAIL_W-1:0] tbl_tail_ff [NENT];
   logic [NENT-1:0]            tbl_valid_ff;

   // Scan window, oldest byte at index 0
   logic [spm_pkg::BYTE_W-1:0] window_ff [spm_pkg::WIN_LEN];
   logic [spm_pkg::BYTE_W-1:0] window_in [spm_pkg::WIN_LEN];
   logic [spm_pkg::FILL_W-1:0] fill_ff;
   logic [spm_pkg::FILL_W-1:0] fill_in;
   logic [spm_pkg::FILL_W-1:0] fill_base;

   // Stage A: item whose window is in window_ff
   logic a_valid_ff, a_scan_ff, a_last_ff;
   // Stage B: registered compare results
   logic                       b_valid_ff, b_scan_ff, b_last_ff;
   logic [spm_pkg::KIND_W-1:0] b_kind_ff;
   logic [NENT-1:0]            b_match_ff;
   logic [NENT-1:0]            b_match_in;
   // Output register and per-file flag
   logic                 rsp_valid_ff;
   spm_pkg::spm_rsp_type rsp_data_ff;
   spm_pkg::spm_rsp_type rsp_data_in;
   logic                 flag_ff;
   logic                 flag_in;

   logic accept, req_scan, req_write, req_clear;
   logic out_free, b_free, a_free, b_move, a_move, a_clr;
   logic pkh_seen, sh_seen;
   logic [spm_pkg::KIND_W-1:0] cand_kind;
   logic [spm_pkg::BYTE_W-1:0] key_byte [spm_pkg::HASH_BYTES];
   logic [spm_pkg::WORD_W-1:0] key_low, key_mid;
   logic [spm_pkg::TAIL_W-1:0] key_tail;
   logic [spm_pkg::ENTRY_W-1:0] enc_entry;
   logic                        any_match;

   // Elastic pipeline control
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign b_free   = !b_valid_ff || out_free;
   assign b_move   = b_valid_ff && out_free;
   assign a_free   = !a_valid_ff || b_free;
   assign a_move   = a_valid_ff && b_free;
   assign req_chan.ready = a_free;
   assign accept   = req_chan.valid && a_free;

   assign req_scan  = req_chan.data.cmd == spm_pkg::CMD_SCAN;
   assign req_write = req_chan.data.cmd == spm_pkg::CMD_WRITE;
   assign req_clear = req_chan.data.cmd == spm_pkg::CMD_CLEAR;

   // A finished file in stage A restarts the window for the next byte
   assign a_clr     = a_valid_ff && a_scan_ff && a_last_ff;
   assign fill_base = a_clr ? '0 : fill_ff;

   // Shift the window and count bytes, saturating at the window length
   always_comb begin
      for (int i = 0; i < spm_pkg::WIN_LEN - 1; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[spm_pkg::WIN_LEN - 1] = req_chan.data.data_byte;
      if (fill_base < spm_pkg::FILL_W'(spm_pkg::WIN_LEN)) begin
         fill_in = fill_base + 1'b1;
      end else begin
         fill_in = fill_base;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_scan) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (accept && req_scan) begin
         fill_ff <= fill_in;
      end else if (a_move && a_clr) begin
         fill_ff <= '0;
      end
   end

   // Load table words; entries beyond the table and word select three drop
   always_ff @(posedge clock) begin
      for (int e = 0; e < NENT; e++) begin
         if (accept && req_write && req_chan.data.entry_index == spm_pkg::ENTRY_W'(e)) begin
            case (req_chan.data.word_select)
               spm_pkg::WSEL_LOW:  tbl_low_ff[e]  <= req_chan.data.load_word;
               spm_pkg::WSEL_MID:  tbl_mid_ff[e]  <= req_chan.data.load_word;
               spm_pkg::WSEL_TAIL: tbl_tail_ff[e] <= req_chan.data.load_word[spm_pkg::TAIL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (accept && req_clear) begin
         tbl_valid_ff <= '0;
      end else if (accept && req_write) begin
         for (int e = 0; e < NENT; e++) begin
            if (req_chan.data.entry_index == spm_pkg::ENTRY_W'(e) &&
                req_chan.data.word_select == spm_pkg::WSEL_TAIL) begin
               tbl_valid_ff[e] <= 1'b1;
            end
         end
      end
   end

   // Detect a template ending at the newest byte
   assign pkh_seen = fill_ff >= spm_pkg::FILL_W'(spm_pkg::WIN_LEN) &&
                     window_ff[0] == spm_pkg::OP_DUP &&
                     window_ff[1] == spm_pkg::OP_HASH160 &&
                     window_ff[2] == spm_pkg::OP_PUSH20 &&
                     window_ff[spm_pkg::WIN_LEN-2] == spm_pkg::OP_EQUALVERIFY &&
                     window_ff[spm_pkg::WIN_LEN-1] == spm_pkg::OP_CHECKSIG;
   assign sh_seen  = fill_ff >= spm_pkg::FILL_W'(spm_pkg::SH_LEN) &&
                     window_ff[spm_pkg::WIN_LEN-spm_pkg::SH_LEN] == spm_pkg::OP_HASH160 &&
                     window_ff[spm_pkg::WIN_LEN-spm_pkg::SH_LEN+1] == spm_pkg::OP_PUSH20 &&
                     window_ff[spm_pkg::WIN_LEN-1] == spm_pkg::OP_EQUAL;

   always_comb begin
      if (!a_scan_ff) begin
         cand_kind = spm_pkg::KIND_NONE;
      end else if (pkh_seen) begin
         cand_kind = spm_pkg::KIND_PKH;
      end else if (sh_seen) begin
         cand_kind = spm_pkg::KIND_SH;
      end else begin
         cand_kind = spm_pkg::KIND_NONE;
      end
   end

   // Pick the hash bytes and pack them into table word order
   always_comb begin
      for (int k = 0; k < spm_pkg::HASH_BYTES; k++) begin
         key_byte[k] = pkh_seen ? window_ff[spm_pkg::PKH_HASH_AT + k]
                                : window_ff[spm_pkg::SH_HASH_AT + k];
      end
      for (int k = 0; k < 8; k++) begin
         key_low[k*8 +: 8] = key_byte[k];
         key_mid[k*8 +: 8] = key_byte[8 + k];
      end
      for (int k = 0; k < 4; k++) begin
         key_tail[k*8 +: 8] = key_byte[16 + k];
      end
   end

   // Compare the candidate against every entry in parallel
   always_comb begin
      for (int e = 0; e < NENT; e++) begin
         b_match_in[e] = (cand_kind != spm_pkg::KIND_NONE) && tbl_valid_ff[e] &&
                         tbl_low_ff[e] == key_low && tbl_mid_ff[e] == key_mid &&
                         tbl_tail_ff[e] == key_tail;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_valid_ff <= req_chan.valid;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   // Advance payload of stages A and B
   always_ff @(posedge clock) begin
      if (accept) begin
         a_scan_ff <= req_scan;
         a_last_ff <= req_chan.data.last_byte;
      end
      if (a_move) begin
         b_scan_ff  <= a_scan_ff;
         b_last_ff  <= a_last_ff;
         b_kind_ff  <= cand_kind;
         b_match_ff <= b_match_in;
      end
   end

   // Lowest matching entry wins
   always_comb begin
      enc_entry = '0;
      for (int e = NENT - 1; e >= 0; e--) begin
         if (b_match_ff[e]) begin
            enc_entry = spm_pkg::ENTRY_W'(e);
         end
      end
      any_match = |b_match_ff;
   end

   // Build the result and update the per-file flag
   always_comb begin
      rsp_data_in.hit_kind   = any_match ? b_kind_ff : spm_pkg::KIND_NONE;
      rsp_data_in.hit_entry  = any_match ? enc_entry : '0;
      rsp_data_in.file_match = flag_ff || any_match;
      rsp_data_in.file_done  = b_scan_ff && b_last_ff;
      flag_in = rsp_data_in.file_done ? 1'b0 : rsp_data_in.file_match;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         flag_ff      <= 1'b0;
      end else begin
         if (out_free) begin
            rsp_valid_ff <= b_valid_ff;
         end
         if (b_move) begin
            flag_ff <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // A reported hit always sets the file flag in the same beat
   hit_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit_kind != spm_pkg::KIND_NONE |-> rsp_data_ff.file_match)
      else $error("hit reported without file_match");

   // No hit means entry zero
   idle_entry_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.hit_kind == spm_pkg::KIND_NONE |-> rsp_data_ff.hit_entry == '0)
      else $error("hit_entry nonzero without a hit");

   // Items without a template never carry compare matches into stage B
   no_stray_match: assert property (@(posedge clock) disable iff (reset)
      a_move && cand_kind == spm_pkg::KIND_NONE |=> b_match_ff == '0)
      else $error("match vector set without a template");

   // Stage B holds only entries that were valid when compared
   match_needs_valid: assert property (@(posedge clock) disable iff (reset)
      a_move |=> (b_match_ff & ~$past(tbl_valid_ff)) == '0)
      else $error("match on an invalid entry");

endmodule

// ===== sim/tb_script_pattern_hash_matcher_core.sv =====
`timescale 1ns / 1ps
// Testbench for the script pattern hash matcher: scan and table traffic checked beat by beat.
module tb_script_pattern_hash_matcher_core;
   import spm_pkg::*;

   localparam logic [CMD_W-1:0]  CMD_IGNORED  = 2'd3;
   localparam logic [WSEL_W-1:0] WSEL_IGNORED = 2'd3;
   localparam int RANDOM_ITEMS = 1250;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 20;

   typedef logic [HASH_BYTES*8-1:0] hash160_type;

   logic clock;
   logic reset;

   spm_req_if req_chan ();
   spm_rsp_if rsp_chan ();

   script_pattern_hash_matcher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state: scan window, hash table, per-file flag
   logic [BYTE_W-1:0] scan_win [WIN_LEN];
   int                scan_fill;
   logic [WORD_W-1:0] hash_words [TABLE_ENTRIES][3];
   bit                hash_live [TABLE_ENTRIES];
   bit                file_hit;

   // Stimulus-side view of what has been loaded into the table
   hash160_type plan_hash [TABLE_ENTRIES];
   bit          plan_lo   [TABLE_ENTRIES];
   bit          plan_mid  [TABLE_ENTRIES];
   bit          plan_live [TABLE_ENTRIES];

   spm_req_type req_backlog[$];
   spm_rsp_type expected_matches[$];

   int   total_items    = 0;
   int   accepted_items = 0;
   int   mismatches     = 0;
   int   cycle_count    = 0;
   bit   req_fire       = 1'b0;
   logic steady;

   // No idling on either side through this stretch of cycles
   assign steady = (cycle_count >= 600) && (cycle_count < 1000);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // Return the lowest live entry matching the 20 hash bytes at base, or -1
   function automatic int find_entry(int base);
      logic [WORD_W-1:0] w0, w1, w2;
      w0 = '0;
      w1 = '0;
      w2 = '0;
      for (int k = 0; k < 8; k++) begin
         w0[8*k +: 8] = scan_win[base + k];
         w1[8*k +: 8] = scan_win[base + 8 + k];
      end
      for (int k = 0; k < 4; k++)
         w2[8*k +: 8] = scan_win[base + 16 + k];
      for (int e = 0; e < TABLE_ENTRIES; e++)
         if (hash_live[e] && hash_words[e][0] == w0 && hash_words[e][1] == w1 &&
             hash_words[e][2][TAIL_W-1:0] == w2[TAIL_W-1:0])
            return e;
      return -1;
   endfunction

   // Apply one item to the predictor and return the result it produces
   function automatic spm_rsp_type predict_match(spm_req_type rq);
      spm_rsp_type rs;
      int          e;
      rs = '0;
      e  = -1;
      case (rq.cmd)
         CMD_WRITE: begin
            if (rq.entry_index < TABLE_ENTRIES && rq.word_select != WSEL_IGNORED) begin
               if (rq.word_select == WSEL_TAIL) begin
                  hash_words[rq.entry_index][2] =
                     {{(WORD_W-TAIL_W){1'b0}}, rq.load_word[TAIL_W-1:0]};
                  hash_live[rq.entry_index] = 1'b1;
               end else begin
                  hash_words[rq.entry_index][rq.word_select] = rq.load_word;
               end
            end
         end
         CMD_CLEAR: begin
            foreach (hash_live[i]) hash_live[i] = 1'b0;
         end
         CMD_SCAN: begin
            // shift the new byte in and look for either template ending here
            for (int k = 0; k < WIN_LEN - 1; k++) scan_win[k] = scan_win[k + 1];
            scan_win[WIN_LEN-1] = rq.data_byte;
            if (scan_fill < WIN_LEN) scan_fill++;
            if (scan_fill >= WIN_LEN && scan_win[0] == OP_DUP && scan_win[1] == OP_HASH160 &&
                scan_win[2] == OP_PUSH20 && scan_win[23] == OP_EQUALVERIFY &&
                scan_win[24] == OP_CHECKSIG) begin
               e = find_entry(PKH_HASH_AT);
               if (e >= 0) rs.hit_kind = KIND_PKH;
            end else if (scan_fill >= SH_LEN && scan_win[WIN_LEN-SH_LEN] == OP_HASH160 &&
                         scan_win[WIN_LEN-SH_LEN+1] == OP_PUSH20 &&
                         scan_win[WIN_LEN-1] == OP_EQUAL) begin
               e = find_entry(SH_HASH_AT);
               if (e >= 0) rs.hit_kind = KIND_SH;
            end
            if (rs.hit_kind != KIND_NONE) begin
               rs.hit_entry = e[ENTRY_W-1:0];
               file_hit     = 1'b1;
            end
            rs.file_done = rq.last_byte;
         end
         default: ;
      endcase
      rs.file_match = file_hit;
      // end of file: drop the window and the sticky flag
      if (rs.file_done) begin
         foreach (scan_win[i]) scan_win[i] = '0;
         scan_fill = 0;
         file_hit  = 1'b0;
      end
      return rs;
   endfunction

   function automatic logic [WORD_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Bias noise toward template bytes so partial templates show up often
   function automatic logic [BYTE_W-1:0] noise_byte();
      case ($urandom_range(9))
         0: return OP_HASH160;
         1: return OP_PUSH20;
         2: return OP_EQUAL;
         3: return OP_DUP;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Pick a hash for a template: mostly a live entry, sometimes stale or random
   function automatic hash160_type pick_hash();
      int live[$];
      int known[$];
      int r;
      foreach (plan_live[e]) begin
         if (plan_live[e]) live.push_back(e);
         if (plan_lo[e] && plan_mid[e]) known.push_back(e);
      end
      r = $urandom_range(99);
      if (r < 65 && live.size() > 0) return plan_hash[live[$urandom_range(live.size() - 1)]];
      if (r < 80 && known.size() > 0) return plan_hash[known[$urandom_range(known.size() - 1)]];
      return {$urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   task automatic queue_item(logic [CMD_W-1:0] cmd, int entry, logic [WSEL_W-1:0] sel,
                             logic [WORD_W-1:0] word, logic [BYTE_W-1:0] data, bit eof);
      spm_req_type rq;
      rq.cmd         = cmd;
      rq.entry_index = entry[ENTRY_W-1:0];
      rq.word_select = sel;
      rq.load_word   = word;
      rq.data_byte   = data;
      rq.last_byte   = eof;
      req_backlog.push_back(rq);
   endtask

   task automatic queue_byte(logic [BYTE_W-1:0] b, bit eof);
      queue_item(CMD_SCAN, $urandom_range(63), 2'($urandom_range(3)), rand_word(), b, eof);
   endtask

   task automatic queue_write(int entry, logic [WSEL_W-1:0] sel, logic [WORD_W-1:0] word);
      case (sel)
         WSEL_LOW: begin
            plan_hash[entry][63:0] = word;
            plan_lo[entry]         = 1'b1;
         end
         WSEL_MID: begin
            plan_hash[entry][127:64] = word;
            plan_mid[entry]          = 1'b1;
         end
         WSEL_TAIL: begin
            plan_hash[entry][159:128] = word[TAIL_W-1:0];
            plan_live[entry]          = 1'b1;
         end
         default: ;
      endcase
      queue_item(CMD_WRITE, entry, sel, word, 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // Load a full entry: low and mid words in either order, then the tail
   task automatic load_entry(int entry, hash160_type h);
      if ($urandom_range(1)) begin
         queue_write(entry, WSEL_LOW, h[63:0]);
         queue_write(entry, WSEL_MID, h[127:64]);
      end else begin
         queue_write(entry, WSEL_MID, h[127:64]);
         queue_write(entry, WSEL_LOW, h[63:0]);
      end
      queue_write(entry, WSEL_TAIL, {$urandom, h[159:128]});
   endtask

   task automatic queue_clear();
      foreach (plan_live[e]) plan_live[e] = 1'b0;
      queue_item(CMD_CLEAR, $urandom_range(63), 2'($urandom_range(3)), rand_word(),
                 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // Emit one template, optionally damaged, cut by end of file, or split by a
   // non-scan item
   task automatic queue_template(bit pkh, hash160_type h, int eof_at, bit damage,
                                 int gap_at);
      logic [BYTE_W-1:0] seq[$];
      int                pos;
      if (pkh) seq.push_back(OP_DUP);
      seq.push_back(OP_HASH160);
      seq.push_back(OP_PUSH20);
      for (int k = 0; k < HASH_BYTES; k++) seq.push_back(h[8*k +: 8]);
      if (pkh) begin
         seq.push_back(OP_EQUALVERIFY);
         seq.push_back(OP_CHECKSIG);
      end else begin
         seq.push_back(OP_EQUAL);
      end
      if (damage) begin
         pos      = $urandom_range(seq.size() - 1);
         seq[pos] = seq[pos] ^ 8'($urandom_range(1, 255));
      end
      foreach (seq[k]) begin
         if (k == gap_at) begin
            if ($urandom_range(1))
               queue_item(CMD_IGNORED, $urandom_range(63), 2'($urandom_range(3)),
                          rand_word(), 8'($urandom_range(255)), 1'($urandom_range(1)));
            else
               queue_write($urandom_range(63), WSEL_IGNORED, rand_word());
         end
         queue_byte(seq[k], k == eof_at);
      end
   endtask

   // Drive request beats and result backpressure on the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_chan.valid || req_fire) begin
            if (req_backlog.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
               req_chan.data  <= req_backlog.pop_front();
               req_chan.valid <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 30);
      end
   end

   // Check result beats, then predict for the accepted request beat
   always @(posedge clock) begin
      spm_rsp_type want;
      if (!reset) begin
         cycle_count <= cycle_count + 1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_matches.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result beat: kind %0d entry %0d match %0d done %0d",
                           rsp_chan.data.hit_kind, rsp_chan.data.hit_entry,
                           rsp_chan.data.file_match, rsp_chan.data.file_done);
            end else begin
               want = expected_matches.pop_front();
               if (rsp_chan.data.hit_kind !== want.hit_kind ||
                   rsp_chan.data.hit_entry !== want.hit_entry ||
                   rsp_chan.data.file_match !== want.file_match ||
                   rsp_chan.data.file_done !== want.file_done) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("result mismatch at %0t (expected/actual): kind %0d/%0d",
                              $time, want.hit_kind, rsp_chan.data.hit_kind,
                              " entry %0d/%0d match %0d/%0d done %0d/%0d",
                              want.hit_entry, rsp_chan.data.hit_entry,
                              want.file_match, rsp_chan.data.file_match,
                              want.file_done, rsp_chan.data.file_done);
               end
            end
         end
         req_fire <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            expected_matches.push_back(predict_match(req_chan.data));
            accepted_items++;
         end
      end
   end

   initial begin
      int pick;
      int tlen;
      int eof_pick;
      int eof_at;
      int gap_at;
      int ready_entries[$];
      bit pkh;

      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      rsp_chan.ready = 1'b0;

      foreach (scan_win[i]) scan_win[i] = '0;
      scan_fill = 0;
      file_hit  = 1'b0;
      for (int e = 0; e < TABLE_ENTRIES; e++) begin
         hash_words[e][0] = '0;
         hash_words[e][1] = '0;
         hash_words[e][2] = '0;
         hash_live[e]     = 1'b0;
         plan_hash[e]     = '0;
         plan_lo[e]       = 1'b0;
         plan_mid[e]      = 1'b0;
         plan_live[e]     = 1'b0;
      end

      // Directed: extreme hashes in the first and last entries, ignored word
      // select and command, then a script-hash form closing out a file
      load_entry(0, {HASH_BYTES*8{1'b1}});
      load_entry(TABLE_ENTRIES - 1, '0);
      queue_write(10, WSEL_IGNORED, {WORD_W{1'b1}});
      queue_item(CMD_IGNORED, 0, WSEL_LOW, '0, 8'hff, 1'b1);
      queue_template(1'b0, '0, SH_LEN - 1, 1'b0, -1);

      // Random: mostly templates in noise, with table traffic mixed in
      while (req_backlog.size() < RANDOM_ITEMS + 30) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            load_entry($urandom_range(TABLE_ENTRIES - 1),
                       ($urandom_range(99) < 30) ? pick_hash()
                          : hash160_type'({$urandom, $urandom, $urandom, $urandom, $urandom}));
         end else if (pick < 6) begin
            queue_write($urandom_range(TABLE_ENTRIES - 1),
                        $urandom_range(1) ? WSEL_LOW : WSEL_MID, rand_word());
         end else if (pick < 7) begin
            // validate only entries whose low and mid words are in place
            ready_entries.delete();
            foreach (plan_lo[e]) if (plan_lo[e] && plan_mid[e]) ready_entries.push_back(e);
            if (ready_entries.size() > 0)
               queue_write(ready_entries[$urandom_range(ready_entries.size() - 1)],
                           WSEL_TAIL, rand_word());
            else
               queue_write($urandom_range(TABLE_ENTRIES - 1), WSEL_IGNORED, rand_word());
         end else if (pick < 8) begin
            queue_write($urandom_range(TABLE_ENTRIES - 1), WSEL_IGNORED, rand_word());
         end else if (pick < 9) begin
            queue_clear();
         end else if (pick < 10) begin
            queue_item(CMD_IGNORED, $urandom_range(63), 2'($urandom_range(3)), rand_word(),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
         end else if (pick < 70) begin
            repeat ($urandom_range(3)) queue_byte(noise_byte(), 1'b0);
            pkh      = 1'($urandom_range(1));
            tlen     = pkh ? WIN_LEN : SH_LEN;
            eof_pick = $urandom_range(99);
            if (eof_pick < 30)
               eof_at = tlen - 1;
            else if (eof_pick < 38)
               eof_at = $urandom_range(tlen - 2);
            else
               eof_at = -1;
            gap_at = ($urandom_range(9) == 0) ? $urandom_range(1, tlen - 1) : -1;
            queue_template(pkh, pick_hash(), eof_at, $urandom_range(99) < 12, gap_at);
         end else begin
            repeat ($urandom_range(1, 6)) queue_byte(noise_byte(), $urandom_range(99) < 6);
         end
      end
      total_items = req_backlog.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come back
      while (accepted_items < total_items || expected_matches.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_matches.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== script_pattern_hash_matcher_core.f =====
hdl/spm_pkg.sv
hdl/spm_req_if.sv
hdl/spm_rsp_if.sv
hdl/script_pattern_hash_matcher_core.sv
sim/tb_script_pattern_hash_matcher_core.sv
